// File: rtl/core/olv_pkg.sv
`default_nettype none

package olv_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 3;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_POP    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } stat_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic rot;
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/olv_cell.sv
`default_nettype none

module olv_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4
) (
  input  wire                            clk_i,
  input  olv_pkg::cell_ctl_t             ctl_i,
  input  wire [IW-1:0]                   pos_i,
  input  wire [olv_pkg::VALUE_W-1:0]     load_i,
  input  wire [olv_pkg::VALUE_W-1:0]     nxt_i,
  output logic [olv_pkg::VALUE_W-1:0]    data_o
);
  import olv_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VALUE_W-1:0] data_q;
  logic [VALUE_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.rot) begin
      data_d = nxt_i;
    end else if (ctl_i.shift && (MY_IDX >= pos_i)) begin
      data_d = nxt_i;
    end else if (ctl_i.load && (MY_IDX == pos_i)) begin
      data_d = load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: rtl/core/ordered_value_list.sv
// Channel | Dir | Group                    | Fields (low bit up)
// --------+-----+--------------------------+-------------------------------------------
// request | in  | s_tvalid/s_tready/tuser  | tuser: req_type[1:0]; tdata: value[31:0]
// result  | out | m_tvalid/m_tready/tuser  | tuser: status[1:0], found[2];
//         |     |                          | tdata: popped_value[31:0], entry_count[36:32]
//
// Append and pop go from acceptance straight to ST_DONE, which registers the result.
// Search and delete rotate the cell ring once in ST_SCAN; a delete that hits then
// passes ST_SHIFT, and both reach ST_DONE, which registers the result.
// One item is in work at a time; the next is taken once the result is registered.
// Reset clears the count and the handshake state; cell contents need no reset.
// A stalled result holds the block in its final state until taken.
`default_nettype none

module ordered_value_list #(
  parameter int unsigned LIST_DEPTH = olv_pkg::LIST_DEPTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_tvalid_i,
  output logic                            s_tready_o,
  input  wire [olv_pkg::VALUE_W-1:0]      s_tdata_i,   // value[31:0]
  input  wire [1:0]                       s_tuser_i,   // req_type[1:0]
  output logic                            m_tvalid_o,
  input  wire                             m_tready_i,
  output logic [olv_pkg::M_TDATA_W-1:0]   m_tdata_o,   // popped_value[31:0], entry_count[36:32]
  output logic [olv_pkg::M_TUSER_W-1:0]   m_tuser_o    // status[1:0], found[2]
);
  import olv_pkg::*;

  localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [IW-1:0] LAST_K = IW'(LIST_DEPTH - 1);

  logic [VALUE_W-1:0] cell_data [LIST_DEPTH];
  cell_ctl_t          ctl;
  logic [IW-1:0]      pos;

  state_e             state_q, state_d;
  logic [CW-1:0]      fill_q, fill_d;
  logic [IW-1:0]      k_q, k_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic               found_q, found_d;
  req_e               req_q, req_d;
  logic [VALUE_W-1:0] val_q, val_d;
  stat_e              stat_q, stat_d;
  logic [VALUE_W-1:0] pop_q, pop_d;

  logic               m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [M_TUSER_W-1:0] m_user_q, m_user_d;

  logic               accept;
  logic               hit;
  req_e               s_req;

  assign s_req      = req_e'(s_tuser_i);
  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign hit        = (CW'(k_q) < fill_q) && (cell_data[0] == val_q) && !found_q;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1) % LIST_DEPTH;
    olv_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .pos_i  (pos),
      .load_i (s_tdata_i),
      .nxt_i  (cell_data[NXT]),
      .data_o (cell_data[i])
    );
  end

  always_comb begin
    ctl       = '0;
    pos       = pos_q;
    state_d   = state_q;
    fill_d    = fill_q;
    k_d       = k_q;
    pos_d     = pos_q;
    found_d   = found_q;
    req_d     = req_q;
    val_d     = val_q;
    stat_d    = stat_q;
    pop_d     = pop_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    if (m_valid_q && m_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d   = s_req;
          val_d   = s_tdata_i;
          found_d = 1'b0;
          pop_d   = '0;
          stat_d  = STAT_OK;
          k_d     = '0;
          unique case (s_req)
            REQ_APPEND: begin
              if (fill_q < DEPTH_C) begin
                ctl.load = 1'b1;
                pos      = fill_q[IW-1:0];
                fill_d   = fill_q + CW'(1);
              end else begin
                stat_d = STAT_FULL;
              end
              state_d = ST_DONE;
            end
            REQ_POP: begin
              if (fill_q != '0) begin
                ctl.shift = 1'b1;
                pos       = '0;
                pop_d     = cell_data[0];
                fill_d    = fill_q - CW'(1);
              end else begin
                stat_d = STAT_EMPTY;
              end
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ctl.rot = 1'b1;
        if (hit) begin
          found_d = 1'b1;
          pos_d   = k_q;
        end
        k_d = k_q + IW'(1);
        if (k_q == LAST_K) begin
          if (!(found_q || hit)) begin
            stat_d  = STAT_NOT_FOUND;
            state_d = ST_DONE;
          end else if (req_q == REQ_DELETE) begin
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SHIFT: begin
        ctl.shift = 1'b1;
        fill_d    = fill_q - CW'(1);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, COUNT_W'(fill_q), pop_q};
          m_user_d  = {found_q, stat_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    pos_q    <= pos_d;
    found_q  <= found_d;
    req_q    <= req_d;
    val_q    <= val_d;
    stat_q   <= stat_d;
    pop_q    <= pop_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

endmodule

`default_nettype wire

// File: rtl/core/olv_checker.sv
`default_nettype none

module olv_checker #(
  parameter int unsigned LIST_DEPTH = olv_pkg::LIST_DEPTH_DEF
) (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             m_tvalid_o,
  input wire                             m_tready_i,
  input wire [olv_pkg::M_TDATA_W-1:0]    m_tdata_o,
  input wire [olv_pkg::M_TUSER_W-1:0]    m_tuser_o
);
  import olv_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_5 = COUNT_W'(LIST_DEPTH);
  localparam bit SMALL = (LIST_DEPTH < 32);

  logic [1:0]         stat;
  logic               found;
  logic [VALUE_W-1:0] popped;
  logic [COUNT_W-1:0] count;

  assign stat   = m_tuser_o[1:0];
  assign found  = m_tuser_o[2];
  assign popped = m_tdata_o[VALUE_W-1:0];
  assign count  = m_tdata_o[VALUE_W+COUNT_W-1:VALUE_W];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o) && $stable(m_tuser_o))
    else $error("result changed while stalled");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (found || (popped != '0)) |-> (stat == STAT_OK))
    else $error("found or popped value with error status");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && SMALL && (stat == STAT_FULL) |-> (count == DEPTH_5))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && (stat == STAT_EMPTY) |-> (count == '0) && (popped == '0))
    else $error("empty status with entries present");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && SMALL |-> (count <= DEPTH_5))
    else $error("count beyond depth");

endmodule

bind ordered_value_list olv_checker #(
  .LIST_DEPTH (LIST_DEPTH)
) u_olv_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);

`default_nettype wire
